>>> sv/cld_pkg.sv
// shared types, constants and a helper function for the content length deframer
`timescale 1ns / 1ps
`default_nettype none
package cld_pkg;

	// width of the declared length accumulator
	localparam int LENGTH_BITS = 32;
	localparam int FLEN_BITS   = 32;

	// header prefix "Content-Length: "
	localparam int PREFIX_LEN  = 16;
	localparam int PREFIX_IDXW = $clog2(PREFIX_LEN);

	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_VT    = 8'h0b;
	localparam logic [7:0] CHAR_FF    = 8'h0c;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	typedef enum logic [2:0] {
		PH_MATCH   = 3'd0,
		PH_RESYNC  = 3'd1,
		PH_DIGITS  = 3'd2,
		PH_SKIP    = 3'd3,
		PH_BLANK   = 3'd4,
		PH_PAYLOAD = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		DIG_NONE  = 2'd0,
		DIG_IN    = 2'd1,
		DIG_ENDED = 2'd2
	} digits_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_FAULT = 2'd1,
		KIND_EMPTY = 2'd2
	} kind_t;

	// one result item
	typedef struct packed {
		kind_t                 kind;
		logic [7:0]            data_byte;
		logic                  last;
		logic [FLEN_BITS-1:0]  frame_length;
	} result_t;

	// expected header character at a prefix position
	function automatic logic [7:0] header_char(input logic [PREFIX_IDXW-1:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h43; // C
			4'd1:    c = 8'h6f; // o
			4'd2:    c = 8'h6e; // n
			4'd3:    c = 8'h74; // t
			4'd4:    c = 8'h65; // e
			4'd5:    c = 8'h6e; // n
			4'd6:    c = 8'h74; // t
			4'd7:    c = 8'h2d; // -
			4'd8:    c = 8'h4c; // L
			4'd9:    c = 8'h65; // e
			4'd10:   c = 8'h6e; // n
			4'd11:   c = 8'h67; // g
			4'd12:   c = 8'h74; // t
			4'd13:   c = 8'h68; // h
			4'd14:   c = 8'h3a; // :
			4'd15:   c = 8'h20; // space
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage : cld_pkg
`default_nettype wire

>>> sv/content_length_deframer_unit.sv
// top level of the content length deframer
// a byte passes from the input byte register through the framing logic into the result register
// throughput: one byte per cycle; the framing state updates once per byte in the parse stage
// the output register frees as its result is taken, so input stalls only when results wait
// reset: asynchronous, returns to header matching with both stages empty
`timescale 1ns / 1ps
`default_nettype none
module content_length_deframer_unit
	import cld_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           in_byte,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                kind,
	output logic [7:0]                data_byte,
	output logic                      last,
	output logic [FLEN_BITS-1:0]      frame_length
);

	logic       space;
	logic       go;
	logic [7:0] byte_s1;
	logic       res_valid;
	result_t    res;
	result_t    res_q;

	// input byte register
	cld_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.space    (space),
		.go       (go),
		.byte_s1  (byte_s1)
	);

	// framing logic
	cld_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	cld_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.res_valid (res_valid),
		.res       (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign kind         = res_q.kind;
	assign data_byte    = res_q.data_byte;
	assign last         = res_q.last;
	assign frame_length = res_q.frame_length;

endmodule : content_length_deframer_unit
`default_nettype wire

>>> sv/cld_in_stage.sv
// input register stage holding one received byte
`timescale 1ns / 1ps
`default_nettype none
module cld_in_stage
	import cld_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       space,
	output logic            go,
	output logic [7:0]      byte_s1
);

	logic valid_s1;

	// the held item moves on whenever the result side has room
	assign go       = valid_s1 && space;
	assign in_ready = !valid_s1 || space;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// byte capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule : cld_in_stage
`default_nettype wire

>>> sv/cld_parse.sv
// framing state machine: header match, resync, length digits, blank line, payload
`timescale 1ns / 1ps
`default_nettype none
module cld_parse
	import cld_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       go,
	input  wire logic [7:0] byte_s1,
	output logic            res_valid,
	output result_t         res
);

	phase_t                 phase_q, phase_d;
	logic [PREFIX_IDXW-1:0] prefix_q, prefix_d;
	logic                   saw_cr_q, saw_cr_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	digits_t                digits_q, digits_d;
	logic [1:0]             depth_q, depth_d;
	logic [LENGTH_BITS-1:0] remain_q, remain_d;

	logic                   is_digit;
	logic                   is_blank;
	logic [7:0]             digit_sub;
	logic [LENGTH_BITS+3:0] len_ext;
	logic [LENGTH_BITS+3:0] len_next_ext;
	logic [LENGTH_BITS-1:0] len_added;
	logic [63:0]            len_wide;
	logic [FLEN_BITS-1:0]   len_flen;
	logic                   remain_le1;

	// byte classes
	assign is_digit  = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign is_blank  = (byte_s1 == CHAR_SPACE) || (byte_s1 == CHAR_TAB) ||
	                   (byte_s1 == CHAR_LF) || (byte_s1 == CHAR_VT) || (byte_s1 == CHAR_FF);
	assign digit_sub = byte_s1 - CHAR_ZERO;

	// times ten plus digit, saturating at all ones
	assign len_ext      = {4'b0000, len_q};
	assign len_next_ext = (len_ext << 3) + (len_ext << 1) +
	                      (LENGTH_BITS+4)'(digit_sub[3:0]);
	assign len_added    = (len_next_ext[LENGTH_BITS+3:LENGTH_BITS] != 4'b0000) ?
	                      {LENGTH_BITS{1'b1}} : len_next_ext[LENGTH_BITS-1:0];

	// low bits of the length for the result
	assign len_wide   = 64'(len_q);
	assign len_flen   = len_wide[FLEN_BITS-1:0];
	assign remain_le1 = (remain_q <= LENGTH_BITS'(1));

	// next state and result
	always_comb begin
		phase_d   = phase_q;
		prefix_d  = prefix_q;
		saw_cr_d  = saw_cr_q;
		len_d     = len_q;
		digits_d  = digits_q;
		depth_d   = depth_q;
		remain_d  = remain_q;
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			PH_MATCH: begin
				if (byte_s1 == header_char(prefix_q)) begin
					if (prefix_q == PREFIX_IDXW'(PREFIX_LEN-1)) begin
						phase_d  = PH_DIGITS;
						prefix_d = '0;
						len_d    = '0;
						digits_d = DIG_NONE;
					end else begin
						prefix_d = prefix_q + 1'b1;
					end
				end else begin
					prefix_d  = '0;
					saw_cr_d  = 1'b0;
					phase_d   = PH_RESYNC;
					res_valid = 1'b1;
					res.kind  = KIND_FAULT;
				end
			end
			PH_RESYNC: begin
				if (saw_cr_q) begin
					saw_cr_d = 1'b0;
					if (byte_s1 == CHAR_LF) begin
						phase_d  = PH_MATCH;
						prefix_d = '0;
					end
				end else if (byte_s1 == CHAR_CR) begin
					saw_cr_d = 1'b1;
				end
			end
			PH_DIGITS: begin
				if (byte_s1 == CHAR_CR) begin
					phase_d = PH_SKIP;
				end else if (digits_q == DIG_NONE) begin
					if (is_digit) begin
						digits_d = DIG_IN;
						len_d    = len_added;
					end else if (!is_blank) begin
						digits_d = DIG_ENDED;
					end
				end else if (digits_q == DIG_IN) begin
					if (is_digit) begin
						len_d = len_added;
					end else begin
						digits_d = DIG_ENDED;
					end
				end
			end
			PH_SKIP: begin
				phase_d = PH_BLANK;
				depth_d = 2'd2;
			end
			PH_BLANK: begin
				case (depth_q)
					2'd0, 2'd2: depth_d = (byte_s1 == CHAR_CR) ? depth_q + 2'd1 : 2'd0;
					2'd1:       depth_d = (byte_s1 == CHAR_LF) ? 2'd2 : 2'd0;
					default: begin
						depth_d = 2'd0;
						if (byte_s1 == CHAR_LF) begin
							if (len_q == '0) begin
								phase_d   = PH_MATCH;
								prefix_d  = '0;
								res_valid = 1'b1;
								res.kind  = KIND_EMPTY;
							end else begin
								remain_d = len_q;
								phase_d  = PH_PAYLOAD;
							end
						end
					end
				endcase
			end
			PH_PAYLOAD: begin
				res_valid        = 1'b1;
				res.kind         = KIND_DATA;
				res.data_byte    = byte_s1;
				res.last         = remain_le1;
				res.frame_length = len_flen;
				if (remain_q != '0) begin
					remain_d = remain_q - 1'b1;
				end
				if (remain_le1) begin
					phase_d  = PH_MATCH;
					prefix_d = '0;
				end
			end
			default: begin
				phase_d  = PH_MATCH;
				prefix_d = '0;
				saw_cr_d = 1'b0;
				len_d    = '0;
				digits_d = DIG_NONE;
				depth_d  = 2'd0;
				remain_d = '0;
			end
		endcase
	end

	// framing state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MATCH;
			prefix_q <= '0;
			saw_cr_q <= 1'b0;
			len_q    <= '0;
			digits_q <= DIG_NONE;
			depth_q  <= 2'd0;
			remain_q <= '0;
		end else if (go) begin
			phase_q  <= phase_d;
			prefix_q <= prefix_d;
			saw_cr_q <= saw_cr_d;
			len_q    <= len_d;
			digits_q <= digits_d;
			depth_q  <= depth_d;
			remain_q <= remain_d;
		end
	end

endmodule : cld_parse
`default_nettype wire

>>> sv/cld_out_stage.sv
// result register facing the output channel
`timescale 1ns / 1ps
`default_nettype none
module cld_out_stage
	import cld_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     go,
	input  wire logic     res_valid,
	input  wire result_t  res,
	output logic          space,
	output logic          out_valid,
	input  wire logic     out_ready,
	output result_t       res_q
);

	logic valid_q;
	logic load;

	assign load      = go && res_valid;
	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;

	// occupancy: a new result takes the slot as the old one leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule : cld_out_stage
`default_nettype wire
